[src/tvt_pkg.sv]
// Shared types, constants and microcode encodings for the touch velocity tracker.
// No dependencies; every other file in src/ depends on this package.
`timescale 1ns / 1ps

package tvt_pkg;

  // Event and payload types
  typedef enum logic [1:0] {
    ACT_DOWN  = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_UP    = 2'd2,
    ACT_OTHER = 2'd3
  } action_t;

  typedef logic signed [15:0] pos_t;
  typedef logic [31:0]        time_t;
  typedef logic signed [16:0] vel_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SLOP_RADIUS  = 1'd0,
    CFG_MAX_VELOCITY = 1'd1
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  SLOP_RESET = 8'd12;
  localparam logic [15:0] MAXV_RESET = 16'd10000;

  // Velocity scale: microseconds per second
  localparam int          USEC_W       = 20;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  localparam int MAG_W  = 16;
  localparam int PROD_W = MAG_W + USEC_W;
  // Quotient bits worth computing; larger quotients saturate anyway
  localparam int DIV_BITS = 16;
  localparam int CNT_W    = $clog2(DIV_BITS);

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Datapath operations, one per microcode step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_MAG_SX,
    OP_MAG_SY,
    OP_SQ,
    OP_ACC_SET,
    OP_ACC_ADD,
    OP_ELAPSED,
    OP_MAG_AX,
    OP_SCALE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_VEL_WR,
    OP_NEXT_AXIS,
    OP_PREV_WR,
    OP_START_WR,
    OP_ZERO,
    OP_EMIT
  } dp_op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_BEAT,
    C_DOWN,
    C_OTHER,
    C_INSIDE,
    C_UP_SAME,
    C_LOOP,
    C_AXIS_LAST,
    C_UP,
    C_OUT_BUSY
  } cond_t;

  typedef logic [4:0] step_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
    logic   cnt_ld;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_down;
    logic is_other;
    logic is_up;
    logic in_slop;
    logic up_same;
    logic axis_last;
    logic out_busy;
  } status_t;

endpackage

[src/tvt_if.sv]
// Handshake channels for pointer event beats and velocity result beats.
// Depends on tvt_pkg for the payload types.
`timescale 1ns / 1ps

interface tvt_in_if;
  logic             valid;
  logic             ready;
  tvt_pkg::action_t action;
  tvt_pkg::pos_t    pos_x;
  tvt_pkg::pos_t    pos_y;
  tvt_pkg::time_t   time_us;

  modport source (output valid, action, pos_x, pos_y, time_us, input ready);
  modport sink   (input valid, action, pos_x, pos_y, time_us, output ready);
endinterface

interface tvt_out_if;
  logic          valid;
  logic          ready;
  tvt_pkg::vel_t velocity_x;
  tvt_pkg::vel_t velocity_y;

  modport source (output valid, velocity_x, velocity_y, input ready);
  modport sink   (input valid, velocity_x, velocity_y, output ready);
endinterface

[src/tvt_seq.sv]
// Microcode sequencer: control ROM, step counter, loop counter and jump logic.
// Depends on tvt_pkg; drives the datapath in tvt_dp.
`timescale 1ns / 1ps

module tvt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  tvt_pkg::status_t  st,
  output tvt_pkg::dp_op_t   op
);
  import tvt_pkg::*;

  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_CHK_DOWN  = 5'd1;
  localparam step_t S_CHK_OTHER = 5'd2;
  localparam step_t S_SX        = 5'd3;
  localparam step_t S_SQX       = 5'd4;
  localparam step_t S_ACCX      = 5'd5;
  localparam step_t S_SY        = 5'd6;
  localparam step_t S_SQY       = 5'd7;
  localparam step_t S_ACCY      = 5'd8;
  localparam step_t S_SLOP      = 5'd9;
  localparam step_t S_UPSAME    = 5'd10;
  localparam step_t S_ELAPSED   = 5'd11;
  localparam step_t S_MAG       = 5'd12;
  localparam step_t S_SCALE     = 5'd13;
  localparam step_t S_DIV_INIT  = 5'd14;
  localparam step_t S_DIV_STEP  = 5'd15;
  localparam step_t S_VEL       = 5'd16;
  localparam step_t S_NEXT_AXIS = 5'd17;
  localparam step_t S_CHK_UP    = 5'd18;
  localparam step_t S_PREV      = 5'd19;
  localparam step_t S_DOWN      = 5'd20;
  localparam step_t S_ZERO      = 5'd21;
  localparam step_t S_OUT_WAIT  = 5'd22;
  localparam step_t S_EMIT      = 5'd23;

  function automatic ucode_t uw(dp_op_t o, cond_t c, step_t t, logic ld);
    ucode_t w;
    w.op     = o;
    w.cond   = c;
    w.target = t;
    w.cnt_ld = ld;
    return w;
  endfunction

  // Control store
  function automatic ucode_t rom(step_t s);
    ucode_t w;
    unique case (s)
      S_IDLE:      w = uw(OP_LATCH,     C_NO_BEAT,   S_IDLE,     1'b0);
      S_CHK_DOWN:  w = uw(OP_NOP,       C_DOWN,      S_DOWN,     1'b0);
      S_CHK_OTHER: w = uw(OP_NOP,       C_OTHER,     S_OUT_WAIT, 1'b0);
      S_SX:        w = uw(OP_MAG_SX,    C_NEXT,      S_IDLE,     1'b0);
      S_SQX:       w = uw(OP_SQ,        C_NEXT,      S_IDLE,     1'b0);
      S_ACCX:      w = uw(OP_ACC_SET,   C_NEXT,      S_IDLE,     1'b0);
      S_SY:        w = uw(OP_MAG_SY,    C_NEXT,      S_IDLE,     1'b0);
      S_SQY:       w = uw(OP_SQ,        C_NEXT,      S_IDLE,     1'b0);
      S_ACCY:      w = uw(OP_ACC_ADD,   C_NEXT,      S_IDLE,     1'b0);
      S_SLOP:      w = uw(OP_NOP,       C_INSIDE,    S_ZERO,     1'b0);
      S_UPSAME:    w = uw(OP_NOP,       C_UP_SAME,   S_OUT_WAIT, 1'b0);
      S_ELAPSED:   w = uw(OP_ELAPSED,   C_NEXT,      S_IDLE,     1'b0);
      S_MAG:       w = uw(OP_MAG_AX,    C_NEXT,      S_IDLE,     1'b0);
      S_SCALE:     w = uw(OP_SCALE,     C_NEXT,      S_IDLE,     1'b0);
      S_DIV_INIT:  w = uw(OP_DIV_INIT,  C_NEXT,      S_IDLE,     1'b1);
      S_DIV_STEP:  w = uw(OP_DIV_STEP,  C_LOOP,      S_DIV_STEP, 1'b0);
      S_VEL:       w = uw(OP_VEL_WR,    C_AXIS_LAST, S_CHK_UP,   1'b0);
      S_NEXT_AXIS: w = uw(OP_NEXT_AXIS, C_ALWAYS,    S_MAG,      1'b0);
      S_CHK_UP:    w = uw(OP_NOP,       C_UP,        S_OUT_WAIT, 1'b0);
      S_PREV:      w = uw(OP_PREV_WR,   C_ALWAYS,    S_OUT_WAIT, 1'b0);
      S_DOWN:      w = uw(OP_START_WR,  C_ALWAYS,    S_OUT_WAIT, 1'b0);
      S_ZERO:      w = uw(OP_ZERO,      C_NEXT,      S_IDLE,     1'b0);
      S_OUT_WAIT:  w = uw(OP_NOP,       C_OUT_BUSY,  S_OUT_WAIT, 1'b0);
      S_EMIT:      w = uw(OP_EMIT,      C_ALWAYS,    S_IDLE,     1'b0);
      default:     w = uw(OP_NOP,       C_ALWAYS,    S_IDLE,     1'b0);
    endcase
    return w;
  endfunction

  step_t            step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ucode_t           uc;
  logic             take;

  always_comb begin
    uc = rom(step_r);
    op = uc.op;
    unique case (uc.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_BEAT:   take = !st.in_valid;
      C_DOWN:      take = st.is_down;
      C_OTHER:     take = st.is_other;
      C_INSIDE:    take = st.in_slop;
      C_UP_SAME:   take = st.up_same;
      C_LOOP:      take = (cnt_r != '0);
      C_AXIS_LAST: take = st.axis_last;
      C_UP:        take = st.is_up;
      C_OUT_BUSY:  take = st.out_busy;
      default:     take = 1'b1;
    endcase
    step_nxt = take ? uc.target : step_t'(step_r + 1'b1);
    cnt_nxt  = cnt_r;
    if (uc.cnt_ld) begin
      cnt_nxt = CNT_W'(DIV_BITS - 1);
    end else if (uc.cond == C_LOOP && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_DIV_STEP |-> ($past(step_r) == S_DIV_INIT || $past(step_r) == S_DIV_STEP))
    else $error("divide loop entered without init");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == S_DIV_STEP && step_nxt != S_DIV_STEP) |-> cnt_r == '0)
    else $error("divide loop left before all quotient bits");

  a_emit_gate: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_EMIT |-> $past(step_r) == S_OUT_WAIT)
    else $error("result emitted without passing output wait");

endmodule

[src/tvt_dp.sv]
// Datapath: event registers, tracker state, shared multiplier, restoring divider,
// saturation, configuration registers and the output register. Depends on tvt_pkg, tvt_if.
`timescale 1ns / 1ps

module tvt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tvt_pkg::dp_op_t                 op,
  output tvt_pkg::status_t                st,
  tvt_in_if.sink                          in_if,
  tvt_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  tvt_pkg::cfg_idx_t               cfg_index,
  input  logic [tvt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tvt_pkg::*;

  // Configuration and tracker state
  logic [7:0]  slop_r;
  logic [15:0] maxv_r;
  pos_t        start_x_r, start_y_r, prev_x_r, prev_y_r;
  time_t       prev_time_r;
  vel_t        vel_x_r, vel_y_r;
  logic        out_valid_r;

  // Working registers
  action_t     act_r;
  pos_t        cur_x_r, cur_y_r;
  time_t       now_r;
  mag_t        mag_r;
  logic        neg_r, nz_r;
  prod_t       prod_r;
  logic [32:0] acc_r;
  time_t       elapsed_r;
  logic        axis_r;
  logic [31:0] rem_r;
  logic [DIV_BITS-1:0] lo_r;
  logic [DIV_BITS-1:0] quo_r;
  logic        ovf_r;
  vel_t        out_vx_r, out_vy_r;

  // Combinational datapath
  pos_t        da, db;
  logic [16:0] diff, diff_neg;
  mag_t        mag_nxt;
  logic [USEC_W-1:0] mul_b;
  prod_t       prod_nxt;
  logic [15:0] slop_sq;
  logic [32:0] div_t, div_sub;
  logic        div_ge;
  logic [31:0] div_hi;
  logic [15:0] qsat;
  vel_t        vel_new;

  always_comb begin
    case (op)
      OP_MAG_SX: begin
        da = cur_x_r;
        db = start_x_r;
      end
      OP_MAG_SY: begin
        da = cur_y_r;
        db = start_y_r;
      end
      default: begin
        da = axis_r ? cur_y_r : cur_x_r;
        db = axis_r ? prev_y_r : prev_x_r;
      end
    endcase
    diff     = {da[15], da} - {db[15], db};
    diff_neg = -diff;
    mag_nxt  = diff[16] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

    mul_b    = (op == OP_SCALE) ? USEC_PER_SEC : {{(USEC_W-MAG_W){1'b0}}, mag_r};
    prod_nxt = {{USEC_W{1'b0}}, mag_r} * {{MAG_W{1'b0}}, mul_b};

    slop_sq  = {8'd0, slop_r} * {8'd0, slop_r};

    // Restoring divide, one quotient bit per step
    div_hi   = {{(64-PROD_W-DIV_BITS){1'b0}}, prod_r[PROD_W-1:DIV_BITS]};
    div_t    = {rem_r, lo_r[DIV_BITS-1]};
    div_ge   = div_t >= {1'b0, elapsed_r};
    div_sub  = div_t - {1'b0, elapsed_r};

    qsat = (ovf_r || quo_r > maxv_r) ? maxv_r : quo_r;
    if (elapsed_r == '0) begin
      vel_new = nz_r ? vel_t'({1'b0, maxv_r}) : '0;
    end else if (neg_r) begin
      vel_new = vel_t'(-{1'b0, qsat});
    end else begin
      vel_new = vel_t'({1'b0, qsat});
    end
  end

  always_comb begin
    st.in_valid  = in_if.valid;
    st.is_down   = (act_r == ACT_DOWN);
    st.is_other  = (act_r == ACT_OTHER);
    st.is_up     = (act_r == ACT_UP);
    st.in_slop   = acc_r <= {17'd0, slop_sq};
    st.up_same   = (act_r == ACT_UP) && cur_x_r == prev_x_r && cur_y_r == prev_y_r;
    st.axis_last = axis_r;
    st.out_busy  = out_valid_r;
  end

  assign in_if.ready       = rst_n && (op == OP_LATCH);
  assign out_if.valid      = out_valid_r;
  assign out_if.velocity_x = out_vx_r;
  assign out_if.velocity_y = out_vy_r;

  // State with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slop_r      <= SLOP_RESET;
      maxv_r      <= MAXV_RESET;
      start_x_r   <= '0;
      start_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_time_r <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLOP_RADIUS:  slop_r <= cfg_data[7:0];
          CFG_MAX_VELOCITY: maxv_r <= cfg_data[15:0];
          default:          slop_r <= slop_r;
        endcase
      end
      case (op)
        OP_START_WR: begin
          start_x_r   <= cur_x_r;
          start_y_r   <= cur_y_r;
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          prev_time_r <= now_r;
        end
        OP_PREV_WR: begin
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          prev_time_r <= now_r;
        end
        OP_VEL_WR: begin
          if (axis_r) begin
            vel_y_r <= vel_new;
          end else begin
            vel_x_r <= vel_new;
          end
        end
        OP_ZERO: begin
          vel_x_r <= '0;
          vel_y_r <= '0;
        end
        default: begin
        end
      endcase
      // Drop the beat once taken; emit only runs with the slot empty
      if (op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        if (in_if.valid) begin
          act_r   <= in_if.action;
          cur_x_r <= in_if.pos_x;
          cur_y_r <= in_if.pos_y;
          now_r   <= in_if.time_us;
        end
      end
      OP_MAG_SX, OP_MAG_SY, OP_MAG_AX: begin
        mag_r <= mag_nxt;
        neg_r <= diff[16];
        nz_r  <= (diff != '0);
      end
      OP_SQ, OP_SCALE: prod_r <= prod_nxt;
      OP_ACC_SET:      acc_r  <= {1'b0, prod_r[31:0]};
      OP_ACC_ADD:      acc_r  <= acc_r + {1'b0, prod_r[31:0]};
      OP_ELAPSED: begin
        elapsed_r <= now_r - prev_time_r;
        axis_r    <= 1'b0;
      end
      OP_DIV_INIT: begin
        // Quotient of 2^16 or more saturates: flag it; the divide steps still run but their bits are ignored
        rem_r <= div_hi;
        ovf_r <= div_hi >= elapsed_r;
        lo_r  <= prod_r[DIV_BITS-1:0];
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? div_sub[31:0] : div_t[31:0];
        lo_r  <= {lo_r[DIV_BITS-2:0], 1'b0};
        quo_r <= {quo_r[DIV_BITS-2:0], div_ge};
      end
      OP_NEXT_AXIS: axis_r <= 1'b1;
      OP_EMIT: begin
        out_vx_r <= vel_x_r;
        out_vy_r <= vel_y_r;
      end
      default: begin
      end
    endcase
  end

  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_EMIT |-> !out_valid_r)
    else $error("result register overwritten while full");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second event taken while one is in work");

  a_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_VEL_WR && elapsed_r == '0 && !axis_r) |=> !vel_x_r[16])
    else $error("zero elapsed time gave negative velocity");

endmodule

[src/touch_velocity_tracker.sv]
// Touch velocity tracker, top level: one event beat in, one velocity beat out.
// Down or ignored event: no arithmetic; inside the slop, or up at the previous point: slop
// test only; up beyond the slop, or move: 16-step divider per axis; each waits on the sink.
// The next event is taken as soon as the previous result sits in the output register.
// Synchronous active-low reset: slop radius 12, max velocity 10000, tracker state zero.
// Depends on tvt_pkg, tvt_if, tvt_seq and tvt_dp.
`timescale 1ns / 1ps

module touch_velocity_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  tvt_in_if.sink                          in_if,
  tvt_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  tvt_pkg::cfg_idx_t               cfg_index,
  input  logic [tvt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tvt_pkg::*;

  dp_op_t  op;
  status_t st;

  tvt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .op    (op)
  );

  tvt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .st        (st),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[dv/tb_touch_velocity_tracker.sv]
// Self-checking testbench for touch_velocity_tracker: directed table, then random gestures.
// Expected velocities come from the directed table or an in-bench tracker model; depends on tvt_pkg and tvt_if.
`timescale 1ns / 1ps

module tb_touch_velocity_tracker;
  import tvt_pkg::*;

  localparam int DIR_N        = 18;
  localparam int PHASE_N      = 6;
  localparam int PHASE_ITEMS  = 190;
  localparam int SETTLE_CYC   = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;
  localparam longint USEC_SEC = 1000000;

  typedef struct packed {
    vel_t vx;
    vel_t vy;
  } vel_pair_t;

  typedef struct packed {
    action_t act;
    pos_t    x;
    pos_t    y;
    time_t   t;
    bit      typed;
    vel_t    ex;
    vel_t    ey;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tvt_in_if  in_ch ();
  tvt_out_if out_ch ();

  touch_velocity_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Tracker model state and its copy of the registers
  logic [7:0]  slop_q;
  logic [15:0] maxv_q;
  pos_t  start_x_q, start_y_q, prev_x_q, prev_y_q;
  time_t prev_t_q;
  vel_t  vel_x_q, vel_y_q;

  vel_pair_t expected_vel [$];
  int mismatches;
  int idle_in_pct;
  int idle_out_pct;
  int stall_cycles;

  // Gesture generator position
  pos_t  g_x, g_y;
  time_t g_t;

  stim_row_t dir_rows [DIR_N] = '{
    '{ACT_OTHER,      0,      0, 32'd0,          1'b1,      0,     0},
    '{ACT_DOWN,     100,    100, 32'd1000,       1'b1,      0,     0},
    '{ACT_MOVE,     105,    105, 32'd2000,       1'b1,      0,     0},
    '{ACT_MOVE,     200,    100, 32'd2000,       1'b1,  10000,     0},
    '{ACT_MOVE,     190,    100, 32'd2000,       1'b1,  10000,     0},
    '{ACT_MOVE,     189,     99, 32'd3000,       1'b1,  -1000, -1000},
    '{ACT_UP,       189,     99, 32'd5000,       1'b1,  -1000, -1000},
    '{ACT_UP,       180,     99, 32'd4000,       1'b1,  -9000,     0},
    '{ACT_UP,       180,     99, 32'd2000,       1'b1,      0,     0},
    '{ACT_DOWN,  -32768, -32768, 32'hFFFF_FFFF,  1'b1,      0,     0},
    '{ACT_MOVE,   32767,  32767, 32'd0,          1'b1,  10000, 10000},
    '{ACT_OTHER,  32767, -32768, 32'hFFFF_FFFF,  1'b1,  10000, 10000},
    '{ACT_DOWN,       0,      0, 32'd100,        1'b1,  10000, 10000},
    '{ACT_UP,         3,      4, 32'd200,        1'b1,      0,     0},
    '{ACT_MOVE,      12,      0, 32'd300,        1'b1,      0,     0},
    '{ACT_MOVE,      12,      1, 32'd300,        1'b0,      0,     0},
    '{ACT_MOVE,      13,      0, 32'd1300,       1'b0,      0,     0},
    '{ACT_UP,        14,     -1, 32'd4300,       1'b0,      0,     0}
  };

  function automatic vel_t axis_rate(int diff, time_t elapsed);
    longint mag;
    longint q;
    if (elapsed == 0) return (diff != 0) ? vel_t'({1'b0, maxv_q}) : vel_t'(0);
    mag = (diff < 0) ? -longint'(diff) : longint'(diff);
    q = (mag * USEC_SEC) / longint'({32'd0, elapsed});
    if (q > longint'(maxv_q)) q = longint'(maxv_q);
    return vel_t'((diff < 0) ? -q : q);
  endfunction

  function automatic void rates_to(pos_t x, pos_t y, time_t t);
    time_t elapsed;
    elapsed = t - prev_t_q;
    vel_x_q = axis_rate(int'(x) - int'(prev_x_q), elapsed);
    vel_y_q = axis_rate(int'(y) - int'(prev_y_q), elapsed);
  endfunction

  // Advance the tracker by one event and return the velocity it reports
  function automatic vel_pair_t track_event(action_t a, pos_t x, pos_t y, time_t t);
    longint dx;
    longint dy;
    bit beyond;
    dx = longint'(x) - longint'(start_x_q);
    dy = longint'(y) - longint'(start_y_q);
    beyond = (dx * dx + dy * dy) > longint'(slop_q) * longint'(slop_q);
    case (a)
      ACT_DOWN: begin
        start_x_q = x;
        start_y_q = y;
        prev_x_q  = x;
        prev_y_q  = y;
        prev_t_q  = t;
      end
      ACT_MOVE: begin
        if (beyond) begin
          rates_to(x, y, t);
          prev_x_q = x;
          prev_y_q = y;
          prev_t_q = t;
        end else begin
          vel_x_q = '0;
          vel_y_q = '0;
        end
      end
      ACT_UP: begin
        if (!beyond) begin
          vel_x_q = '0;
          vel_y_q = '0;
        end else if (x != prev_x_q || y != prev_y_q) begin
          rates_to(x, y, t);
        end
      end
      default: ;
    endcase
    return '{vx: vel_x_q, vy: vel_y_q};
  endfunction

  // Drive one event beat and record its expectation when it is taken
  task automatic send_event(action_t a, pos_t x, pos_t y, time_t t,
                            bit typed = 1'b0, vel_pair_t typed_v = '0);
    vel_pair_t v;
    if (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= a;
    in_ch.pos_x   <= x;
    in_ch.pos_y   <= y;
    in_ch.time_us <= t;
    do @(posedge clk); while (!in_ch.ready);
    v = track_event(a, x, y, t);
    expected_vel.push_back(typed ? typed_v : v);
  endtask

  // Hold off the sender until every expected beat is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_vel.size() != 0);
  endtask

  task automatic write_config(logic [7:0] slop, logic [15:0] maxv);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOP_RADIUS;
    cfg_data  <= {8'($urandom_range(255)), slop};
    @(posedge clk);
    cfg_index <= CFG_MAX_VELOCITY;
    cfg_data  <= maxv;
    @(posedge clk);
    cfg_we <= 1'b0;
    slop_q = slop;
    maxv_q = maxv;
  endtask

  function automatic pos_t nudge(pos_t p);
    int s;
    case ($urandom_range(3))
      0: s = 3;
      1: s = 30;
      2: s = 400;
      default: return pos_t'($urandom);
    endcase
    return pos_t'(int'(p) + int'($urandom_range(0, 2 * s)) - s);
  endfunction

  function automatic time_t tick(time_t t);
    case ($urandom_range(7))
      0: return t;
      1: return t + $urandom_range(1, 20);
      6: return t + $urandom_range(20000, 2000000);
      7: return time_t'($urandom);
      default: return t + $urandom_range(100, 20000);
    endcase
  endfunction

  // Mostly whole gestures (down, moves, up) with random content; some noise beats
  task automatic send_gestures(int n);
    int sent;
    int moves;
    pos_t ux, uy;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 15) begin
        send_event(action_t'($urandom_range(3)), pos_t'($urandom), pos_t'($urandom),
                   time_t'($urandom));
        sent++;
      end else begin
        if ($urandom_range(1)) begin
          g_x = pos_t'($urandom);
          g_y = pos_t'($urandom);
        end else begin
          g_x = pos_t'(int'($urandom_range(0, 2000)) - 1000);
          g_y = pos_t'(int'($urandom_range(0, 2000)) - 1000);
        end
        g_t = tick(g_t);
        send_event(ACT_DOWN, g_x, g_y, g_t);
        moves = $urandom_range(1, 8);
        repeat (moves) begin
          g_x = nudge(g_x);
          g_y = nudge(g_y);
          g_t = tick(g_t);
          send_event(ACT_MOVE, g_x, g_y, g_t);
        end
        // Lift either at the last move point or somewhere new
        ux = $urandom_range(2) == 0 ? g_x : nudge(g_x);
        uy = $urandom_range(2) == 0 ? g_y : nudge(g_y);
        g_t = tick(g_t);
        send_event(ACT_UP, ux, uy, g_t);
        sent += moves + 2;
      end
      if (sent % 64 < 10 && $urandom_range(9) == 0) wait_drained();
    end
  endtask

  // Receiver: random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // Compare each velocity beat with the oldest expectation
  always @(posedge clk) begin : check_vel
    vel_pair_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_vel.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected velocity beat: vx=%0d vy=%0d",
                   out_ch.velocity_x, out_ch.velocity_y);
      end else begin
        head = expected_vel.pop_front();
        if (out_ch.velocity_x !== head.vx || out_ch.velocity_y !== head.vy) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("velocity mismatch: exp vx=%0d vy=%0d, got vx=%0d vy=%0d",
                     head.vx, head.vy, out_ch.velocity_x, out_ch.velocity_y);
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[touch_velocity_tracker] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SLOP_RADIUS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_OTHER;
    in_ch.pos_x   <= '0;
    in_ch.pos_y   <= '0;
    in_ch.time_us <= '0;
    idle_in_pct  = 0;
    idle_out_pct = 0;
    slop_q    = SLOP_RESET;
    maxv_q    = MAXV_RESET;
    start_x_q = '0;
    start_y_q = '0;
    prev_x_q  = '0;
    prev_y_q  = '0;
    prev_t_q  = '0;
    vel_x_q   = '0;
    vel_y_q   = '0;
    g_x = '0;
    g_y = '0;
    g_t = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_event(dir_rows[i].act, dir_rows[i].x, dir_rows[i].y, dir_rows[i].t,
                 dir_rows[i].typed, '{vx: dir_rows[i].ex, vy: dir_rows[i].ey});
    end

    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0: ;
        1: write_config(8'd0, 16'd1);
        2: write_config(8'd255, 16'd65535);
        3: write_config(8'($urandom_range(40)), 16'd0);
        default: write_config(8'($urandom_range(60)), 16'($urandom_range(1, 65535)));
      endcase
      case (ph % 4)
        0: begin idle_in_pct = 0;  idle_out_pct = 0;  end
        1: begin idle_in_pct = 77; idle_out_pct = 0;  end
        2: begin idle_in_pct = 0;  idle_out_pct = 77; end
        default: begin idle_in_pct = 8; idle_out_pct = 8; end
      endcase
      send_gestures(PHASE_ITEMS);
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && expected_vel.size() == 0) begin
      $display("[touch_velocity_tracker] OK");
    end else begin
      $display("[touch_velocity_tracker] ERROR");
    end
    $finish;
  end

endmodule
